FILE: sv/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared constants, types and control/status bundles for the PFC duty block.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int RAMP_STEPS      = 5;
    localparam int FRAC_BITS       = 14;
    localparam int DUTY_WIDTH      = 16;
    localparam int COUNT_WIDTH     = 3;
    localparam int GATE_COUNT      = 4;
    localparam int DVD_WIDTH       = SAMPLE_WIDTH + FRAC_BITS;
    localparam int DVS_WIDTH       = SAMPLE_WIDTH;
    localparam int PROD_WIDTH      = SAMPLE_WIDTH + COUNT_WIDTH;
    localparam int RECIP_SHIFT     = PROD_WIDTH + COUNT_WIDTH;
    localparam int RECIP_WIDTH     = RECIP_SHIFT + 1;
    localparam int SCALE_WIDTH     = PROD_WIDTH + RECIP_WIDTH;
    localparam int QSUM_WIDTH      = DVD_WIDTH + 2;
    localparam int DIV_CNT_WIDTH   = $clog2(DVD_WIDTH + 1);
    localparam int IN_TDATA_WIDTH  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_BITS        = DUTY_WIDTH + GATE_COUNT + 2;
    localparam int OUT_TDATA_WIDTH = ((OUT_BITS + 7) / 8) * 8;

    // ceil(2^RECIP_SHIFT / RAMP_STEPS): exact quotient for any ramp product
    localparam logic [RECIP_WIDTH-1:0] RAMP_RECIP =
        RECIP_WIDTH'(((1 << RECIP_SHIFT) + RAMP_STEPS - 1) / RAMP_STEPS);

    localparam logic signed [QSUM_WIDTH-1:0] DUTY_ONE = QSUM_WIDTH'(1 << FRAC_BITS);
    localparam logic signed [QSUM_WIDTH-1:0] DUTY_MAX =
        QSUM_WIDTH'((1 << (DUTY_WIDTH - 1)) - 1);
    localparam logic signed [QSUM_WIDTH-1:0] DUTY_MIN = -(DUTY_MAX + 1);

    localparam logic [GATE_COUNT-1:0] GATES_ALL  = 4'b1111;
    localparam logic [GATE_COUNT-1:0] GATES_LEG2 = 4'b0010;
    localparam logic [GATE_COUNT-1:0] GATES_LEG1 = 4'b0001;
    localparam logic [GATE_COUNT-1:0] GATES_OFF  = 4'b0000;

    typedef enum logic [1:0] {
        ACT_PFC   = 2'd0,
        ACT_INV   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_TRACK = 2'd1,
        PH_RAMP  = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RAMP_MUL,
        ST_RAMP_SCALE,
        ST_DUTY_DIV,
        ST_DUTY_WAIT,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                   accept;
        logic                   clear_state;
        logic                   update_last;
        logic                   load_target;
        logic                   load_product;
        logic                   div_start;
        logic                   load_opnd_cmd;
        logic                   load_opnd_act;
        logic                   finish;
        logic                   zero_result;
        logic                   out_load;
        logic [COUNT_WIDTH-1:0] ramp_count;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    crossing;
        logic    div_done;
        logic    out_free;
    } ctrl_stat_t;

endpackage

FILE: sv/pfc_div.sv
// ----------------------------------------------------------------------------
// pfc_div
// Restoring serial divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pfc_pkg::DVD_WIDTH-1:0]  dividend,
    input  logic [pfc_pkg::DVS_WIDTH-1:0]  divisor,
    output logic                           done,
    output logic [pfc_pkg::DVD_WIDTH-1:0]  quotient
);
    import pfc_pkg::*;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DIV_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [DVS_WIDTH-1:0]     rem_reg, rem_next;
    logic [DVS_WIDTH-1:0]     dvs_reg, dvs_next;
    logic [DVD_WIDTH-1:0]     quo_reg, quo_next;
    logic [DVS_WIDTH:0]       shifted;
    logic [DVS_WIDTH:0]       diff;
    logic                     fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DVD_WIDTH-1]};
        diff      = shifted - {1'b0, dvs_reg};
        fits      = (shifted >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_WIDTH'(DVD_WIDTH);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_WIDTH-1:0] : shifted[DVS_WIDTH-1:0];
            quo_next = {quo_reg[DVD_WIDTH-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/pfc_datapath.sv
// ----------------------------------------------------------------------------
// pfc_datapath
// Sample registers, ramp scaling, duty divider, duty saturation, output reg.
// ----------------------------------------------------------------------------
module pfc_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pfc_pkg::ctrl_cmd_t                   cmd,
    output pfc_pkg::ctrl_stat_t                  stat,
    input  logic [1:0]                           in_action,
    input  logic [pfc_pkg::IN_TDATA_WIDTH-1:0]   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [pfc_pkg::OUT_TDATA_WIDTH-1:0]  out_data
);
    import pfc_pkg::*;

    action_t                        action_reg;
    logic signed [SAMPLE_WIDTH-1:0] cmd_reg;
    logic signed [SAMPLE_WIDTH-1:0] bus_reg;
    logic signed [SAMPLE_WIDTH-1:0] last_reg;
    logic signed [SAMPLE_WIDTH-1:0] target_reg;
    logic signed [SAMPLE_WIDTH-1:0] opnd_reg;
    logic [PROD_WIDTH-1:0]          prod_mag_reg;
    logic                           prod_neg_reg;
    logic [GATE_COUNT-1:0]          gates_reg;
    logic [DUTY_WIDTH-1:0]          duty_res_reg;
    logic                           off_res_reg;
    logic                           sat_res_reg;
    logic                           out_valid_reg;
    logic [OUT_TDATA_WIDTH-1:0]     out_data_reg;

    logic [SAMPLE_WIDTH-1:0]        target_mag;
    logic [SAMPLE_WIDTH-1:0]        opnd_mag;
    logic [SAMPLE_WIDTH-1:0]        bus_mag;
    logic [DVD_WIDTH-1:0]           div_dividend;
    logic [DVS_WIDTH-1:0]           div_divisor;
    logic                           div_done;
    logic [DVD_WIDTH-1:0]           div_quo;
    logic [SCALE_WIDTH-1:0]         recip_prod;
    logic [SAMPLE_WIDTH-1:0]        act_mag;
    logic signed [SAMPLE_WIDTH-1:0] act;
    logic                           act_pos;
    logic                           opnd_nonpos;
    logic                           quo_neg;
    logic signed [QSUM_WIDTH-1:0]   q_mag_s;
    logic signed [QSUM_WIDTH-1:0]   q_signed;
    logic signed [QSUM_WIDTH-1:0]   q_sum;
    logic [DUTY_WIDTH-1:0]          duty_sat;
    logic                           sat_flag;
    logic                           out_free;

    always_comb
    begin
        target_mag  = target_reg[SAMPLE_WIDTH-1] ? -target_reg : target_reg;
        opnd_mag    = opnd_reg[SAMPLE_WIDTH-1] ? -opnd_reg : opnd_reg;
        bus_mag     = (bus_reg == '0) ? SAMPLE_WIDTH'(1)
                    : (bus_reg[SAMPLE_WIDTH-1] ? -bus_reg : bus_reg);
        div_dividend = {opnd_mag, {FRAC_BITS{1'b0}}};
        div_divisor  = bus_mag;
        // ramp product divided by the step count via reciprocal multiply
        recip_prod  = SCALE_WIDTH'(prod_mag_reg) * SCALE_WIDTH'(RAMP_RECIP);
        act_mag     = recip_prod[RECIP_SHIFT +: SAMPLE_WIDTH];
        act         = prod_neg_reg ? -$signed(act_mag) : $signed(act_mag);
        act_pos     = !act[SAMPLE_WIDTH-1] && (act != '0);
        opnd_nonpos = opnd_reg[SAMPLE_WIDTH-1] || (opnd_reg == '0);
        quo_neg     = opnd_reg[SAMPLE_WIDTH-1] ^ bus_reg[SAMPLE_WIDTH-1];
        q_mag_s     = $signed(QSUM_WIDTH'(div_quo));
        q_signed    = quo_neg ? -q_mag_s : q_mag_s;
        q_sum       = opnd_nonpos ? q_signed + DUTY_ONE : q_signed;
        if (q_sum > DUTY_MAX)
        begin
            duty_sat = DUTY_MAX[DUTY_WIDTH-1:0];
            sat_flag = 1'b1;
        end
        else if (q_sum < DUTY_MIN)
        begin
            duty_sat = DUTY_MIN[DUTY_WIDTH-1:0];
            sat_flag = 1'b1;
        end
        else
        begin
            duty_sat = q_sum[DUTY_WIDTH-1:0];
            sat_flag = 1'b0;
        end
        out_free = !out_valid_reg || out_ready;
    end

    pfc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // state that a clear or reset returns to zero; reset also drops out_valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            target_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_state)
            begin
                last_reg   <= '0;
                target_reg <= '0;
            end
            else
            begin
                if (cmd.update_last)
                    last_reg <= cmd_reg;
                if (cmd.load_target)
                    target_reg <= cmd_reg;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg <= action_t'(in_action);
            cmd_reg    <= in_data[SAMPLE_WIDTH-1:0];
            bus_reg    <= in_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        end
        if (cmd.load_product)
        begin
            prod_mag_reg <= PROD_WIDTH'(target_mag) * PROD_WIDTH'(cmd.ramp_count);
            prod_neg_reg <= target_reg[SAMPLE_WIDTH-1];
        end
        if (cmd.load_opnd_cmd)
        begin
            opnd_reg  <= cmd_reg;
            gates_reg <= GATES_ALL;
        end
        else if (cmd.load_opnd_act)
        begin
            opnd_reg  <= act;
            gates_reg <= act_pos ? GATES_LEG2 : GATES_LEG1;
        end
        else if (cmd.zero_result)
            gates_reg <= GATES_OFF;
        if (cmd.finish)
        begin
            duty_res_reg <= duty_sat;
            off_res_reg  <= opnd_nonpos;
            sat_res_reg  <= sat_flag;
        end
        else if (cmd.zero_result)
        begin
            duty_res_reg <= '0;
            off_res_reg  <= 1'b0;
            sat_res_reg  <= 1'b0;
        end
        if (cmd.out_load)
            out_data_reg <= OUT_TDATA_WIDTH'({sat_res_reg, gates_reg, off_res_reg,
                                              duty_res_reg});
    end

    assign stat.action   = action_reg;
    assign stat.crossing = (cmd_reg == '0) || (last_reg == '0)
                         || (cmd_reg[SAMPLE_WIDTH-1] != last_reg[SAMPLE_WIDTH-1]);
    assign stat.div_done = div_done;
    assign stat.out_free = out_free;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

FILE: sv/pfc_ctrl.sv
// ----------------------------------------------------------------------------
// pfc_ctrl
// Sequencer for one sample and the PFC start/track/ramp state machine.
// ----------------------------------------------------------------------------
module pfc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    input  pfc_pkg::ctrl_stat_t  stat,
    output pfc_pkg::ctrl_cmd_t   cmd
);
    import pfc_pkg::*;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_START;
            count_reg  <= '0;
            enable_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            if (cfg_valid)
                enable_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        cmd            = '0;
        cmd.ramp_count = count_reg;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                case (stat.action)
                    ACT_CLEAR:
                    begin
                        cmd.clear_state = 1'b1;
                        phase_next      = PH_START;
                        count_next      = '0;
                        state_next      = ST_IDLE;
                    end
                    ACT_INV:
                    begin
                        cmd.load_opnd_cmd = 1'b1;
                        state_next        = ST_DUTY_DIV;
                    end
                    ACT_PFC:
                    begin
                        cmd.update_last = 1'b1;
                        case (phase_reg)
                            PH_TRACK:
                            begin
                                if (stat.crossing)
                                begin
                                    cmd.zero_result = 1'b1;
                                    cmd.load_target = 1'b1;
                                    phase_next      = PH_RAMP;
                                    count_next      = '0;
                                    state_next      = ST_EMIT;
                                end
                                else
                                begin
                                    cmd.load_opnd_cmd = 1'b1;
                                    state_next        = ST_DUTY_DIV;
                                end
                            end
                            PH_RAMP:
                            begin
                                if (count_reg < COUNT_WIDTH'(RAMP_STEPS))
                                begin
                                    count_next = count_reg + 1'b1;
                                    state_next = ST_RAMP_MUL;
                                end
                                else
                                begin
                                    phase_next        = PH_TRACK;
                                    cmd.load_opnd_cmd = 1'b1;
                                    state_next        = ST_DUTY_DIV;
                                end
                            end
                            default:
                            begin
                                if (enable_reg)
                                    phase_next = PH_TRACK;
                                cmd.load_opnd_cmd = 1'b1;
                                state_next        = ST_DUTY_DIV;
                            end
                        endcase
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RAMP_MUL:
            begin
                cmd.load_product = 1'b1;
                state_next       = ST_RAMP_SCALE;
            end
            ST_RAMP_SCALE:
            begin
                cmd.load_opnd_act = 1'b1;
                state_next        = ST_DUTY_DIV;
            end
            ST_DUTY_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DUTY_WAIT;
            end
            ST_DUTY_WAIT:
            begin
                if (stat.div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/pfc_duty_zero_cross_ramp.sv
// ----------------------------------------------------------------------------
// pfc_duty_zero_cross_ramp
// Totem-pole PFC / inverter duty generator with zero-crossing soft ramp.
// ----------------------------------------------------------------------------
// Input stream s_*: one transfer per sample, s_tuser selects PFC sample,
// inverter sample or state clear; s_tdata carries command and bus voltage.
// Output stream m_*: one transfer per PFC or inverter sample, none for a
// clear or an unused action code.
// Config channel cfg_*: one bit, zero-cross ramp enable, always ready; write
// it only while no sample is in flight.
// One sample at a time. A normal sample runs through the 30-step serial
// divider (one quotient bit per cycle) before it reaches m_tvalid.
// A ramp sample first scales the latched target by the ramp count over the
// ramp steps with a constant reciprocal multiply. The zero-crossing
// all-off sample skips the divider. A new sample is taken only after the
// last one has been loaded into the output register; s_tready is high
// only between samples.
// The result sits in an output register: the next sample is taken while it
// waits, and the block holds a finished result until m_tready frees the slot.
// Reset clears the ramp enable, the PFC state machine, the last command
// and the ramp target, and drops m_tvalid.
// ----------------------------------------------------------------------------
module pfc_duty_zero_cross_ramp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [15:0] command_voltage, [31:16] bus_voltage
    input  logic [pfc_pkg::IN_TDATA_WIDTH-1:0]   s_tdata,
    // [1:0] action
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [15:0] duty, [16] offset_bit, [17] gate_en_1, [18] gate_en_2,
    // [19] gate_en_3, [20] gate_en_4, [21] saturated, [23:22] zero
    output logic [pfc_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data
);
    import pfc_pkg::*;

    ctrl_cmd_t  ctrl_cmd;
    ctrl_stat_t ctrl_stat;

    assign cfg_ready = 1'b1;

    pfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .stat      (ctrl_stat),
        .cmd       (ctrl_cmd)
    );

    pfc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctrl_cmd),
        .stat      (ctrl_stat),
        .in_action (s_tuser),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PFC duty generator with zero-crossing ramp.
// Samples go in on the s_* stream; every result on m_* is checked field by
// field against a cycle-free model of the duty division and of the PFC
// start / tracking / ramping sequence. Directed extremes and crossing ramps
// come first, then random sign runs that keep the state machine crossing and
// ramping. Both stream sides stall at random until the final calm stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                   saturated;
        logic [GATE_COUNT-1:0]  gates;
        logic                   offset_bit;
        logic signed [15:0]     duty;
    } duty_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [IN_TDATA_WIDTH-1:0]   s_tdata;
    logic [1:0]                  s_tuser;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [OUT_TDATA_WIDTH-1:0]  m_tdata;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic                        cfg_data;

    // model state
    logic                        ramp_enable = 1'b0;
    logic [1:0]                  phase       = PH_START;
    longint                      last_cmd    = 0;
    longint                      ramp_tgt    = 0;
    logic [COUNT_WIDTH-1:0]      ramp_cnt    = '0;

    duty_result_t                duty_expected[$];
    bit                          calm        = 1'b0;
    int                          run_sign    = 1;
    int                          fail_count  = 0;
    int                          items_sent  = 0;
    int                          results_seen = 0;
    int                          blanks_seen = 0;
    int                          ramp_seen   = 0;
    int                          clipped_seen = 0;
    int                          quiet_cycles = 0;

    pfc_duty_zero_cross_ramp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic duty_result_t divide_duty(longint cmd, longint bus,
                                                 logic [GATE_COUNT-1:0] gates);
        longint       divisor;
        longint       q;
        duty_result_t r;
        divisor = (bus == 0) ? 1 : bus;
        q = (cmd * longint'(DUTY_ONE)) / divisor;
        r = '0;
        r.gates = gates;
        if (cmd <= 0)
        begin
            r.offset_bit = 1'b1;
            q += longint'(DUTY_ONE);
        end
        if (q > longint'(DUTY_MAX))
        begin
            q = longint'(DUTY_MAX);
            r.saturated = 1'b1;
        end
        else if (q < longint'(DUTY_MIN))
        begin
            q = longint'(DUTY_MIN);
            r.saturated = 1'b1;
        end
        r.duty = q[15:0];
        return r;
    endfunction

    // returns 1 when the sample yields a result
    function automatic bit duty_step(action_t act, logic [15:0] cmd_bits,
                                     logic [15:0] bus_bits, output duty_result_t r);
        longint cmd;
        longint bus;
        longint ramp_v;
        cmd = longint'($signed(cmd_bits));
        bus = longint'($signed(bus_bits));
        r = '0;
        case (act)
            ACT_CLEAR:
            begin
                phase    = PH_START;
                last_cmd = 0;
                ramp_tgt = 0;
                ramp_cnt = '0;
                return 1'b0;
            end
            ACT_NONE:
                return 1'b0;
            ACT_INV:
            begin
                r = divide_duty(cmd, bus, GATES_ALL);
                return 1'b1;
            end
            default:
            begin
                if (phase == PH_TRACK)
                begin
                    if (cmd * last_cmd <= 0)
                    begin
                        phase    = PH_RAMP;
                        r        = '0;
                        ramp_tgt = cmd;
                        ramp_cnt = '0;
                    end
                    else
                        r = divide_duty(cmd, bus, GATES_ALL);
                end
                else if (phase == PH_RAMP)
                begin
                    if (ramp_cnt < RAMP_STEPS)
                    begin
                        ramp_cnt = ramp_cnt + 1'b1;
                        ramp_v = (ramp_tgt * longint'(ramp_cnt)) / longint'(RAMP_STEPS);
                        r = divide_duty(ramp_v, bus, (ramp_v > 0) ? GATES_LEG2 : GATES_LEG1);
                    end
                    else
                    begin
                        phase = PH_TRACK;
                        r = divide_duty(cmd, bus, GATES_ALL);
                    end
                end
                else
                begin
                    if (ramp_enable)
                        phase = PH_TRACK;
                    r = divide_duty(cmd, bus, GATES_ALL);
                end
                last_cmd = cmd;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(string field, int want, int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        duty_result_t want;
        duty_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(duty_result_t)-1:0];
            results_seen++;
            if (duty_expected.size() == 0)
            begin
                fail_count++;
                $display("%0t ns: unexpected result, expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = duty_expected.pop_front();
                check_field("duty", want.duty, got.duty);
                check_field("offset_bit", want.offset_bit, got.offset_bit);
                for (int g = 0; g < GATE_COUNT; g++)
                    check_field($sformatf("gate_en_%0d", g + 1), want.gates[g], got.gates[g]);
                check_field("saturated", want.saturated, got.saturated);
                if (want.gates == GATES_OFF)
                    blanks_seen++;
                if (want.gates == GATES_LEG1 || want.gates == GATES_LEG2)
                    ramp_seen++;
                if (want.saturated)
                    clipped_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // sink side back-pressure
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(action_t act, logic [15:0] cmd, logic [15:0] bus);
        duty_result_t r;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {bus, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        if (duty_step(act, cmd, bus, r))
            duty_expected.push_back(r);
        items_sent++;
    endtask

    // wait for every result, then let a zero-result sample drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (duty_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(logic value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        ramp_enable = value;
    endtask

    function automatic logic [15:0] pick_voltage(int want);
        int mag;
        if ($urandom_range(0, 19) == 0)
            return '0;
        if (want == 0)
            return 16'($urandom);
        case ($urandom_range(0, 5))
            0:       mag = 32767;
            1, 2:    mag = $urandom_range(1, 300);
            default: mag = $urandom_range(1, 32767);
        endcase
        if (want > 0)
            return 16'(mag);
        if (mag == 32767 && $urandom_range(0, 1) == 1)
            return 16'h8000;
        return 16'(-mag);
    endfunction

    function automatic logic [15:0] pick_bus();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'($urandom);
            2:       return 16'($urandom_range(1, 64));
            default: return 16'($urandom_range(256, 32767));
        endcase
    endfunction

    task automatic random_samples(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_item(ACT_CLEAR, 16'($urandom), 16'($urandom));
            else if (r < 5)
                send_item(ACT_NONE, 16'($urandom), 16'($urandom));
            else if (r < 17)
                send_item(ACT_INV, pick_voltage(0), pick_bus());
            else
            begin
                if ($urandom_range(0, 9) < 4)
                    run_sign = -run_sign;
                send_item(ACT_PFC, pick_voltage(run_sign), pick_bus());
            end
        end
    endtask

    // ramp disabled: saturation, zero bus and offset corners in full drive
    task automatic test_duty_extremes();
        send_item(ACT_INV, 16'sd32767, 16'sd1);
        send_item(ACT_INV, -16'sd32768, 16'sd1);
        send_item(ACT_PFC, 16'sd0, 16'sd0);
        send_item(ACT_PFC, -16'sd32768, -16'sd32768);
        send_item(ACT_INV, 16'sd32767, -16'sd32768);
        send_item(ACT_PFC, -16'sd1, 16'sd32767);
        send_item(ACT_INV, 16'sd1, 16'sd0);
    endtask

    // two full crossings: negative target, then a zero command target
    task automatic test_zero_cross_ramp();
        write_enable(1'b1);
        send_item(ACT_CLEAR, 16'hffff, 16'hffff);
        send_item(ACT_PFC, 16'sd1000, 16'sd2000);
        send_item(ACT_PFC, 16'sd1200, 16'sd2000);
        send_item(ACT_NONE, 16'sd0, 16'sd0);
        send_item(ACT_PFC, -16'sd800, 16'sd2000);
        send_item(ACT_PFC, 16'sd5, 16'sd3000);
        send_item(ACT_PFC, -16'sd5, 16'sd0);
        send_item(ACT_INV, 16'sd300, 16'sd900);
        send_item(ACT_PFC, 16'sd9, -16'sd3000);
        send_item(ACT_PFC, 16'sd9, 16'sd1);
        send_item(ACT_PFC, 16'sd9, 16'sd500);
        send_item(ACT_PFC, 16'sd700, 16'sd1500);
        // enable dropped mid-run; tracking carries on
        write_enable(1'b0);
        send_item(ACT_PFC, 16'sd0, 16'sd1000);
        repeat (RAMP_STEPS + 1)
            send_item(ACT_PFC, 16'sd400, 16'sd1000);
    endtask

    task automatic test_random_tracking();
        write_enable(1'b1);
        random_samples(350);
    endtask

    task automatic test_random_disabled();
        write_enable(1'b0);
        random_samples(120);
    endtask

    task automatic test_random_calm();
        write_enable(1'b1);
        calm = 1'b1;
        random_samples(230);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= ACT_PFC;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_duty_extremes();
        test_zero_cross_ramp();
        test_random_tracking();
        test_random_disabled();
        test_random_calm();
        settle();

        $display("run: %0d samples in, %0d results checked", items_sent, results_seen);
        $display("run: %0d crossing blanks, %0d ramp steps, %0d clipped duties",
                 blanks_seen, ramp_seen, clipped_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
sv/pfc_pkg.sv
sv/pfc_div.sv
sv/pfc_datapath.sv
sv/pfc_ctrl.sv
sv/pfc_duty_zero_cross_ramp.sv
verif/tb_top.sv
